// ===== hw/rtl/tamr_pkg.sv =====
// shared constants for the tensor axis max-reduce block
package tamr_pkg;

    // parameter defaults
    localparam int MAX_DIMS_DEF     = 4;
    localparam int MAX_DIM_SIZE_DEF = 1024;
    localparam int OUT_DEPTH_DEF    = 4096;
    localparam int DATA_WIDTH_DEF   = 16;

    // configuration port layout
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int DIMS_W     = 3;
    localparam int SIZE_W     = 11;
    localparam int MASK_W     = 4;

    // number of extent registers, and the index width over them
    localparam int SIZE_REGS = 4;
    localparam int DIM_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM3   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCE_MASK = 3'd5;

    // reset values of the configuration registers
    localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1;
    localparam logic [MASK_W-1:0] MASK_RESET = 4'd0;

endpackage

// ===== hw/rtl/tamr_ram.sv =====
// generic simple dual-port ram with registered read
module tamr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tensor_axis_max_reduce.sv =====
// top level of the streaming max-reduce over selected tensor axes
// Takes one tensor element per cycle while the update stage does not stall,
// in row-major order (last used dimension fastest), and keeps running maxima
// in a single ram addressed row-major over the kept dimensions; the first
// element of a group writes its entry, later ones keep the larger value, and
// the last element of a group produces one result (index, max, tensor-end
// flag, too-large flag). Sustained rate is one element per clock while the
// output queue has room: each element costs one ram read at accept and one
// write from the update stage, and a forwarding register covers back-to-back
// hits on the same entry. A result passes the update stage and then the
// output queue before it shows at the output; a two-entry output queue keeps
// the input side running while results wait. The ram is never cleared (no
// reset pass): a group's first element writes its entry before any read value
// is used. Any configuration write restarts the tensor; the too_large flag is
// derived from the extents through a short registered multiply.
module tensor_axis_max_reduce #(
    parameter int MAX_DIMS     = tamr_pkg::MAX_DIMS_DEF,
    parameter int MAX_DIM_SIZE = tamr_pkg::MAX_DIM_SIZE_DEF,
    parameter int OUT_DEPTH    = tamr_pkg::OUT_DEPTH_DEF,
    parameter int DATA_WIDTH   = tamr_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tamr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tamr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // element input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [DATA_WIDTH-1:0]          i_sample,
    // result output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [((OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1)-1:0] o_out_index,
    output logic signed [DATA_WIDTH-1:0]          o_max_value,
    output logic                                  o_final_res,
    output logic                                  o_too_large
);

    localparam int NREG  = tamr_pkg::SIZE_REGS;
    // dimensions that can actually be in use
    localparam int ND    = (MAX_DIMS < NREG) ? MAX_DIMS : NREG;
    localparam int SZ_W  = (tamr_pkg::SIZE_W > $clog2(MAX_DIM_SIZE + 1)) ?
                           tamr_pkg::SIZE_W : $clog2(MAX_DIM_SIZE + 1);
    localparam int CNT_W = $clog2(MAX_DIM_SIZE);
    localparam int AW    = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    // saturated kept-product width, holds OUT_DEPTH + 1
    localparam int OW    = $clog2(OUT_DEPTH + 2);
    localparam int DW    = DATA_WIDTH;
    localparam int PW    = 2 * SZ_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [tamr_pkg::DIMS_W-1:0] r_dims;
    logic [tamr_pkg::SIZE_W-1:0] r_size [NREG];
    logic [tamr_pkg::MASK_W-1:0] r_mask;

    logic cfg_acc;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= tamr_pkg::DIMS_RESET;
            for (int d = 0; d < NREG; d++) begin
                r_size[d] <= tamr_pkg::SIZE_RESET;
            end
            r_mask <= tamr_pkg::MASK_RESET;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                tamr_pkg::REG_DIMS_IN_USE: begin
                    r_dims <= i_cfg_data[tamr_pkg::DIMS_W-1:0];
                end
                tamr_pkg::REG_SIZE_DIM0: begin
                    r_size[0] <= i_cfg_data[tamr_pkg::SIZE_W-1:0];
                end
                tamr_pkg::REG_SIZE_DIM1: begin
                    r_size[1] <= i_cfg_data[tamr_pkg::SIZE_W-1:0];
                end
                tamr_pkg::REG_SIZE_DIM2: begin
                    r_size[2] <= i_cfg_data[tamr_pkg::SIZE_W-1:0];
                end
                tamr_pkg::REG_SIZE_DIM3: begin
                    r_size[3] <= i_cfg_data[tamr_pkg::SIZE_W-1:0];
                end
                tamr_pkg::REG_REDUCE_MASK: begin
                    r_mask <= i_cfg_data[tamr_pkg::MASK_W-1:0];
                end
                default: begin
                    // unknown index: only restarts the tensor
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // effective shape: clamped dim count, clamped extents, reduced set
    // ------------------------------------------------------------------
    logic [tamr_pkg::DIMS_W-1:0] n_used;
    logic [NREG-1:0]             used;
    logic [NREG-1:0]             mask_used;
    logic [NREG-1:0]             red;
    logic [SZ_W-1:0]             sz   [NREG];
    logic [SZ_W-1:0]             kk   [NREG];

    always_comb begin
        if (r_dims == '0) begin
            n_used = tamr_pkg::DIMS_W'(1);
        end else if (r_dims > tamr_pkg::DIMS_W'(ND)) begin
            n_used = tamr_pkg::DIMS_W'(ND);
        end else begin
            n_used = r_dims;
        end
        for (int d = 0; d < NREG; d++) begin
            used[d]      = (d < ND) && (tamr_pkg::DIMS_W'(d) < n_used);
            mask_used[d] = used[d] & r_mask[d];
            if (r_size[d] == '0) begin
                sz[d] = SZ_W'(1);
            end else if (SZ_W'(r_size[d]) > SZ_W'(MAX_DIM_SIZE)) begin
                sz[d] = SZ_W'(MAX_DIM_SIZE);
            end else begin
                sz[d] = SZ_W'(r_size[d]);
            end
        end
        // empty selection over the used dims means reduce everything
        red = (mask_used == '0) ? used : mask_used;
        for (int d = 0; d < NREG; d++) begin
            kk[d] = (used[d] && !red[d]) ? sz[d] : SZ_W'(1);
        end
    end

    // too_large: product of kept extents against the store depth,
    // two pairwise products, then a saturated product and compare
    logic [PW-1:0]   r_p01;
    logic [PW-1:0]   r_p23;
    logic [OW-1:0]   s01;
    logic [OW-1:0]   s23;
    logic [2*OW-1:0] sprod;
    logic            r_too_large;

    always_ff @(posedge i_clk) begin
        r_p01 <= PW'(kk[0]) * PW'(kk[1]);
        r_p23 <= PW'(kk[2]) * PW'(kk[3]);
    end

    always_comb begin
        s01   = (r_p01 > PW'(OUT_DEPTH)) ? OW'(OUT_DEPTH + 1) : OW'(r_p01);
        s23   = (r_p23 > PW'(OUT_DEPTH)) ? OW'(OUT_DEPTH + 1) : OW'(r_p23);
        sprod = (2 * OW)'(s01) * (2 * OW)'(s23);
    end

    always_ff @(posedge i_clk) begin
        r_too_large <= (sprod > (2 * OW)'(OUT_DEPTH));
    end

    // ------------------------------------------------------------------
    // position tracking: per-dim counters, current store address and,
    // per dim, the address seen when every inner counter was last zero
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] r_cnt  [NREG];
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    r_base [NREG];

    logic [CNT_W-1:0]              n_cnt  [NREG];
    logic [AW-1:0]                 n_idx;
    logic [AW-1:0]                 n_base [NREG];
    logic [NREG-1:0]               at_end;
    logic                          first;
    logic                          grp_last;
    logic                          tns_last;
    logic                          inc_found;
    logic [tamr_pkg::DIM_IDX_W-1:0] inc_dim;

    logic in_acc;
    assign in_acc = i_in_valid & o_in_ready;

    always_comb begin
        first     = 1'b1;
        grp_last  = 1'b1;
        tns_last  = 1'b1;
        inc_found = 1'b0;
        inc_dim   = '0;
        for (int d = 0; d < NREG; d++) begin
            at_end[d] = (SZ_W'(r_cnt[d]) >= (sz[d] - SZ_W'(1)));
            if (used[d]) begin
                if (!at_end[d]) begin
                    tns_last  = 1'b0;
                    // innermost dim that still has room takes the step
                    inc_found = 1'b1;
                    inc_dim   = tamr_pkg::DIM_IDX_W'(d);
                end
                if (red[d]) begin
                    if (r_cnt[d] != '0) begin
                        first = 1'b0;
                    end
                    if (!at_end[d]) begin
                        grp_last = 1'b0;
                    end
                end
            end
        end

        // kept dim steps: next row-major entry; reduced dim steps: back to
        // the entry where its inner block began
        if (!inc_found) begin
            n_idx = '0;
        end else if (!red[inc_dim]) begin
            n_idx = (r_idx == AW'(OUT_DEPTH - 1)) ? '0 : (r_idx + AW'(1));
        end else begin
            n_idx = r_base[inc_dim];
        end

        for (int d = 0; d < NREG; d++) begin
            if (!inc_found) begin
                n_cnt[d]  = '0;
                n_base[d] = '0;
            end else if (tamr_pkg::DIM_IDX_W'(d) == inc_dim) begin
                n_cnt[d]  = r_cnt[d] + CNT_W'(1);
                n_base[d] = n_idx;
            end else if (tamr_pkg::DIM_IDX_W'(d) > inc_dim) begin
                n_cnt[d]  = '0;
                n_base[d] = n_idx;
            end else begin
                n_cnt[d]  = r_cnt[d];
                n_base[d] = r_base[d];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_acc) begin
            r_idx <= '0;
            for (int d = 0; d < NREG; d++) begin
                r_cnt[d]  <= '0;
                r_base[d] <= '0;
            end
        end else if (in_acc) begin
            r_idx <= n_idx;
            for (int d = 0; d < NREG; d++) begin
                r_cnt[d]  <= n_cnt[d];
                r_base[d] <= n_base[d];
            end
        end
    end

    // ------------------------------------------------------------------
    // running-max store and the update stage
    // ------------------------------------------------------------------
    logic                 r_s1_valid;
    logic [AW-1:0]        r_s1_addr;
    logic signed [DW-1:0] r_s1_sample;
    logic                 r_s1_first;
    logic                 r_s1_last;
    logic                 r_s1_tlast;
    logic                 r_fwd;
    logic signed [DW-1:0] r_fwd_data;

    logic [DW-1:0]        ram_rdata;
    logic signed [DW-1:0] cur_max;
    logic signed [DW-1:0] upd_max;
    logic                 s1_adv;
    logic                 q_push;
    logic                 q_pop;
    logic [1:0]           r_q_cnt;

    tamr_ram #(
        .WIDTH (DW),
        .DEPTH (OUT_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata (upd_max),
        .i_re    (in_acc),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        // the previous element wrote this entry in the read cycle
        cur_max = r_fwd ? r_fwd_data : $signed(ram_rdata);
        upd_max = (r_s1_first || (r_s1_sample > cur_max)) ? r_s1_sample : cur_max;
    end

    // stage moves on unless its result finds the output queue full
    assign s1_adv     = r_s1_valid && (!r_s1_last || (r_q_cnt != 2'd2));
    assign q_push     = s1_adv && r_s1_last;
    assign o_in_ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
            r_fwd      <= s1_adv && (r_s1_addr == r_idx);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr   <= r_idx;
            r_s1_sample <= i_sample;
            r_s1_first  <= first;
            r_s1_last   <= grp_last;
            r_s1_tlast  <= tns_last;
            r_fwd_data  <= upd_max;
        end
    end

    // ------------------------------------------------------------------
    // two-entry result queue
    // ------------------------------------------------------------------
    logic [AW-1:0]        r_q_addr  [2];
    logic signed [DW-1:0] r_q_max   [2];
    logic                 r_q_final [2];
    logic                 r_q_wptr;
    logic                 r_q_rptr;

    assign o_out_valid = (r_q_cnt != 2'd0);
    assign q_pop       = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt  <= 2'd0;
            r_q_wptr <= 1'b0;
            r_q_rptr <= 1'b0;
        end else begin
            r_q_cnt <= r_q_cnt + {1'b0, q_push} - {1'b0, q_pop};
            if (q_push) begin
                r_q_wptr <= !r_q_wptr;
            end
            if (q_pop) begin
                r_q_rptr <= !r_q_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q_addr[r_q_wptr]  <= r_s1_addr;
            r_q_max[r_q_wptr]   <= upd_max;
            r_q_final[r_q_wptr] <= r_s1_tlast;
        end
    end

    assign o_out_index = r_q_addr[r_q_rptr];
    assign o_max_value = r_q_max[r_q_rptr];
    assign o_final_res = r_q_final[r_q_rptr];
    // changes only with configuration; the user must keep the block idle
    assign o_too_large = r_too_large;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt != 2'd3)
        else $error("result queue overflow");

    a_fwd_needs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid)
        else $error("forwarding with empty update stage");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_acc |=> (r_idx == '0 && r_cnt[0] == '0 && r_base[0] == '0))
        else $error("configuration write did not restart the tensor");

    a_push_only_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_s1_valid) |-> s1_adv)
        else $error("new request overwrote a stalled element");

endmodule
